// File: design/arbd_pkg.sv
`timescale 1ns / 1ps

package arbd_pkg;

  // Sample width and the stream widths that follow from it
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned WARMUP_W    = 8;
  localparam int unsigned STABLE_W    = 4;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  // Register indexes, byte address 4*index
  typedef enum logic [2:0] {
    REG_BASELINE,
    REG_SET_MIDPOINT,
    REG_BEND_RISES,
    REG_USE_SET_POINTS,
    REG_STABLE_COUNT,
    REG_WARMUP_TICKS,
    REG_RANGE_NEEDED,
    REG_FALLBACK_BAND
  } reg_idx_e;

  // Which rule produced the raw decision
  typedef enum logic [1:0] {
    RULE_SET,
    RULE_DOWN,
    RULE_UP,
    RULE_BAND
  } rule_e;

  typedef struct packed {
    smp_t                baseline;
    smp_t                set_midpoint;
    logic                bend_rises;
    logic                use_set_points;
    logic [STABLE_W-1:0] stable_count;
    logic [WARMUP_W-1:0] warmup_ticks;
    smp_t                range_needed;
    smp_t                fallback_band;
  } cfg_t;

  typedef struct packed {
    logic [WARMUP_W-1:0] warmup_left;
    smp_t                seen_min;
    smp_t                seen_max;
    logic                bent;
    logic [RUN_W-1:0]    change_run;
  } state_t;

  typedef struct packed {
    logic  bent;
    logic  raw_decision;
    rule_e rule_used;
  } result_t;

  // Reset values
  localparam logic [STABLE_W-1:0] STABLE_RST = STABLE_W'(3);
  localparam logic [WARMUP_W-1:0] WARMUP_RST = WARMUP_W'(25);
  localparam smp_t                RANGE_RST  = SAMPLE_BITS'(50);
  localparam smp_t                BAND_RST   = SAMPLE_BITS'(60);
  localparam logic [RUN_W-1:0]    RUN_MAX    = {RUN_W{1'b1}};

endpackage

// File: design/arbd_step.sv
`timescale 1ns / 1ps

// Per-item update: warm-up and extreme tracking, rule choice, debounce
module arbd_step (
  input  arbd_pkg::smp_t    sample_i,
  input  arbd_pkg::cfg_t    cfg_i,
  input  arbd_pkg::state_t  state_i,
  output arbd_pkg::state_t  state_o,
  output arbd_pkg::result_t result_o
);
  import arbd_pkg::*;

  smp_t                 min_n;
  smp_t                 max_n;
  logic [WARMUP_W-1:0]  warm_n;
  smp_t                 down;
  smp_t                 up;
  smp_t                 mid_down;
  smp_t                 mid_up;
  smp_t                 dev;
  logic [SAMPLE_BITS:0] sum_down;
  logic [SAMPLE_BITS:0] sum_up;
  logic                 cand;
  rule_e                rule;
  logic [RUN_W-1:0]     run_inc;

  // Warm-up countdown, reseed on the last tick, then track extremes
  always_comb begin
    warm_n = state_i.warmup_left;
    min_n  = state_i.seen_min;
    max_n  = state_i.seen_max;
    if (state_i.warmup_left != '0) begin
      warm_n = state_i.warmup_left - WARMUP_W'(1);
      if (warm_n == '0) begin
        min_n = sample_i;
        max_n = sample_i;
      end
    end else begin
      if (sample_i < state_i.seen_min) min_n = sample_i;
      if (sample_i > state_i.seen_max) max_n = sample_i;
    end
  end

  // Observed range either side of the baseline and the auto midpoints
  assign down     = (min_n < cfg_i.baseline) ? cfg_i.baseline - min_n : '0;
  assign up       = (max_n > cfg_i.baseline) ? max_n - cfg_i.baseline : '0;
  assign sum_down = {1'b0, cfg_i.baseline} + {1'b0, min_n};
  assign sum_up   = {1'b0, cfg_i.baseline} + {1'b0, max_n};
  assign mid_down = sum_down[SAMPLE_BITS:1];
  assign mid_up   = sum_up[SAMPLE_BITS:1];
  assign dev      = (sample_i >= cfg_i.baseline) ? sample_i - cfg_i.baseline
                                                 : cfg_i.baseline - sample_i;

  // Rule selection
  always_comb begin
    if (cfg_i.use_set_points) begin
      rule = RULE_SET;
      cand = cfg_i.bend_rises ? (sample_i > cfg_i.set_midpoint)
                              : (sample_i < cfg_i.set_midpoint);
    end else if (down > cfg_i.range_needed && down >= up) begin
      rule = RULE_DOWN;
      cand = sample_i < mid_down;
    end else if (up > cfg_i.range_needed && up > down) begin
      rule = RULE_UP;
      cand = sample_i > mid_up;
    end else begin
      rule = RULE_BAND;
      cand = dev > cfg_i.fallback_band;
    end
  end

  // Debounce: saturating run of differing decisions
  assign run_inc = (state_i.change_run == RUN_MAX) ? RUN_MAX
                                                   : state_i.change_run + RUN_W'(1);

  always_comb begin
    state_o             = state_i;
    state_o.warmup_left = warm_n;
    state_o.seen_min    = min_n;
    state_o.seen_max    = max_n;
    if (cand == state_i.bent) begin
      state_o.change_run = '0;
    end else if (run_inc >= RUN_W'(cfg_i.stable_count)) begin
      state_o.bent       = cand;
      state_o.change_run = '0;
    end else begin
      state_o.change_run = run_inc;
    end
  end

  assign result_o.bent         = state_o.bent;
  assign result_o.raw_decision = cand;
  assign result_o.rule_used    = rule;

endmodule

// File: design/auto_ranging_bend_detector.sv
`timescale 1ns / 1ps
// Latency: a sample accepted into the input register passes through the step logic into the
// result register, which drives the output port; a held output stalls that transfer.
// Throughput: one sample per cycle while the output is not held back; the channel state is updated
// by the step logic between the input register and the result register.
// Reset (rst_ni low, asynchronous): valid flags, configuration and channel state return to their
// defaults, the warm-up counter reloads to 25, min/max to zero, state straight.

module auto_ranging_bend_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream; tdata: [11:0] sample, rest zero
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [arbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Result stream; tdata: [0] bent, [1] raw_decision, [3:2] rule_used
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [arbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [arbd_pkg::PADDR_W-1:0]         paddr,
  input  logic [arbd_pkg::PDATA_W-1:0]         pwdata,
  output logic [arbd_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready
);
  import arbd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  state_t   st_q, st_d, st_next;
  result_t  res_next;
  result_t  out_q;
  logic     out_vld_q;
  logic     in_vld_q;
  smp_t     in_smp_q;
  logic     adv;
  logic     step;
  logic     wr;
  reg_idx_e idx;
  smp_t     wdata_smp;

  // Handshake: input register feeds the result register
  assign adv           = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (adv)           out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_smp_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    if (step)                           out_q    <= res_next;
  end

  arbd_step u_step (
    .sample_i (in_smp_q),
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .state_o  (st_next),
    .result_o (res_next)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-4){1'b0}}, out_q.rule_used,
                          out_q.raw_decision, out_q.bent};

  // Register port
  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wdata_smp = pwdata[SAMPLE_BITS-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_BASELINE:       cfg_d.baseline       = wdata_smp;
        REG_SET_MIDPOINT:   cfg_d.set_midpoint   = wdata_smp;
        REG_BEND_RISES:     cfg_d.bend_rises     = pwdata[0];
        REG_USE_SET_POINTS: cfg_d.use_set_points = pwdata[0];
        REG_STABLE_COUNT:   cfg_d.stable_count   = pwdata[STABLE_W-1:0];
        REG_WARMUP_TICKS:   cfg_d.warmup_ticks   = pwdata[WARMUP_W-1:0];
        REG_RANGE_NEEDED:   cfg_d.range_needed   = wdata_smp;
        REG_FALLBACK_BAND:  cfg_d.fallback_band  = wdata_smp;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASELINE:       prdata = PDATA_W'(cfg_q.baseline);
      REG_SET_MIDPOINT:   prdata = PDATA_W'(cfg_q.set_midpoint);
      REG_BEND_RISES:     prdata = PDATA_W'(cfg_q.bend_rises);
      REG_USE_SET_POINTS: prdata = PDATA_W'(cfg_q.use_set_points);
      REG_STABLE_COUNT:   prdata = PDATA_W'(cfg_q.stable_count);
      REG_WARMUP_TICKS:   prdata = PDATA_W'(cfg_q.warmup_ticks);
      REG_RANGE_NEEDED:   prdata = PDATA_W'(cfg_q.range_needed);
      REG_FALLBACK_BAND:  prdata = PDATA_W'(cfg_q.fallback_band);
      default:            prdata = '0;
    endcase
  end

  // Channel state: step update, or side effects of a register write
  always_comb begin
    st_d = st_q;
    if (step) begin
      st_d = st_next;
    end else if (wr) begin
      if (idx == REG_BASELINE && st_q.warmup_left != '0) begin
        st_d.seen_min = wdata_smp;
        st_d.seen_max = wdata_smp;
      end
      if (idx == REG_WARMUP_TICKS) st_d.warmup_left = pwdata[WARMUP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline       <= '0;
      cfg_q.set_midpoint   <= '0;
      cfg_q.bend_rises     <= 1'b0;
      cfg_q.use_set_points <= 1'b0;
      cfg_q.stable_count   <= STABLE_RST;
      cfg_q.warmup_ticks   <= WARMUP_RST;
      cfg_q.range_needed   <= RANGE_RST;
      cfg_q.fallback_band  <= BAND_RST;
      st_q.warmup_left     <= WARMUP_RST;
      st_q.seen_min        <= '0;
      st_q.seen_max        <= '0;
      st_q.bent            <= 1'b0;
      st_q.change_run      <= '0;
    end else begin
      cfg_q <= cfg_d;
      st_q  <= st_d;
    end
  end

  // Checks
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.seen_min <= st_q.seen_max)
    else $error("tracked minimum above maximum");

  a_bent_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(st_q.bent))
    else $error("bent state changed without an item");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("item lost between input and result register");

  a_rule_set_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> ((out_q.rule_used == RULE_SET) == $past(cfg_q.use_set_points)))
    else $error("set-point rule does not follow its enable");

endmodule

// File: tb/sv/auto_ranging_bend_detector_tb.sv
`timescale 1ns / 1ps

module auto_ranging_bend_detector_tb;
  import arbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: [11:0] sample, rest zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: [0] bent, [1] raw_decision, [3:2] rule_used
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]     pwdata = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  auto_ranging_bend_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Samples waiting to be driven, and the decisions expected back
  smp_t    sample_q[$];
  result_t bend_exp_q[$];

  // Own copy of the channel registers and state
  cfg_t   cfg;
  state_t st;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Sample profile generator state
  int seg_left = 0;
  int seg_kind = 0;
  int seg_target = 0;

  function automatic smp_t clip_smp(input int v);
    if (v < 0) return '0;
    if (v > (1 << SAMPLE_BITS) - 1) return '1;
    return smp_t'(v);
  endfunction

  function automatic logic [PDATA_W-1:0] reg_mask(input reg_idx_e idx);
    case (idx)
      REG_BEND_RISES, REG_USE_SET_POINTS: return 32'h1;
      REG_STABLE_COUNT:                   return 32'hF;
      REG_WARMUP_TICKS:                   return 32'hFF;
      default:                            return (32'h1 << SAMPLE_BITS) - 1;
    endcase
  endfunction

  // Mostly short gaps, a few long ones; calm stretches have none
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PDATA_W-1:0] pick12();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return (32'h1 << SAMPLE_BITS) - 1;
      default: return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return (32'h1 << SAMPLE_BITS) - 1;
      2:       return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] pick_warmup();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd255;
      default: return $urandom_range(2, 30);
    endcase
  endfunction

  task automatic reset_model();
    cfg.baseline       = '0;
    cfg.set_midpoint   = '0;
    cfg.bend_rises     = 1'b0;
    cfg.use_set_points = 1'b0;
    cfg.stable_count   = STABLE_RST;
    cfg.warmup_ticks   = WARMUP_RST;
    cfg.range_needed   = RANGE_RST;
    cfg.fallback_band  = BAND_RST;
    st.warmup_left     = WARMUP_RST;
    st.seen_min        = '0;
    st.seen_max        = '0;
    st.bent            = 1'b0;
    st.change_run      = '0;
  endtask

  // Register write as the block sees it, with its side effects on the state
  task automatic apply_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] w);
    case (idx)
      REG_BASELINE: begin
        cfg.baseline = w[SAMPLE_BITS-1:0];
        // min/max follow the baseline only while warming up
        if (st.warmup_left != 0) begin
          st.seen_min = cfg.baseline;
          st.seen_max = cfg.baseline;
        end
      end
      REG_SET_MIDPOINT:   cfg.set_midpoint = w[SAMPLE_BITS-1:0];
      REG_BEND_RISES:     cfg.bend_rises = w[0];
      REG_USE_SET_POINTS: cfg.use_set_points = w[0];
      REG_STABLE_COUNT:   cfg.stable_count = w[STABLE_W-1:0];
      REG_WARMUP_TICKS: begin
        cfg.warmup_ticks = w[WARMUP_W-1:0];
        st.warmup_left   = w[WARMUP_W-1:0];
      end
      REG_RANGE_NEEDED:   cfg.range_needed = w[SAMPLE_BITS-1:0];
      REG_FALLBACK_BAND:  cfg.fallback_band = w[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Bend decision for one accepted sample
  task automatic predict_bend(input smp_t s);
    logic [SAMPLE_BITS:0] mid;
    smp_t    down;
    smp_t    up;
    smp_t    dev;
    logic    cand;
    rule_e   rule;
    result_t r;

    // warm-up, reseed on its last tick, then extreme tracking
    if (st.warmup_left != 0) begin
      st.warmup_left = st.warmup_left - 1'b1;
      if (st.warmup_left == 0) begin
        st.seen_min = s;
        st.seen_max = s;
      end
    end else begin
      if (s < st.seen_min) st.seen_min = s;
      if (s > st.seen_max) st.seen_max = s;
    end

    down = (st.seen_min < cfg.baseline) ? cfg.baseline - st.seen_min : '0;
    up   = (st.seen_max > cfg.baseline) ? st.seen_max - cfg.baseline : '0;

    if (cfg.use_set_points) begin
      rule = RULE_SET;
      cand = cfg.bend_rises ? (s > cfg.set_midpoint) : (s < cfg.set_midpoint);
    end else if (down > cfg.range_needed && down >= up) begin
      rule = RULE_DOWN;
      mid  = ({1'b0, cfg.baseline} + {1'b0, st.seen_min}) >> 1;
      cand = {1'b0, s} < mid;
    end else if (up > cfg.range_needed && up > down) begin
      rule = RULE_UP;
      mid  = ({1'b0, cfg.baseline} + {1'b0, st.seen_max}) >> 1;
      cand = {1'b0, s} > mid;
    end else begin
      rule = RULE_BAND;
      dev  = (s >= cfg.baseline) ? s - cfg.baseline : cfg.baseline - s;
      cand = dev > cfg.fallback_band;
    end

    // debounce; a zero stable count flips at once
    if (cand == st.bent) begin
      st.change_run = '0;
    end else begin
      if (st.change_run != RUN_MAX) st.change_run = st.change_run + 1'b1;
      if (st.change_run >= cfg.stable_count) begin
        st.bent       = cand;
        st.change_run = '0;
      end
    end

    r.bent         = st.bent;
    r.raw_decision = cand;
    r.rule_used    = rule;
    bend_exp_q.push_back(r);
  endtask

  // Register write: setup then access; junk above the register width
  task automatic cfg_write(input reg_idx_e idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] w;
    w = (val & reg_mask(idx)) | ($urandom & ~reg_mask(idx));
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, w);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Rest stretches, bends of random depth, noise and rail values
  task automatic queue_sample();
    smp_t s;
    if (seg_left == 0) begin
      seg_left = $urandom_range(3, 30);
      seg_kind = $urandom_range(0, 9);
      if (seg_kind < 4) begin
        seg_target = int'(cfg.baseline);
      end else if ($urandom_range(0, 1)) begin
        seg_target = int'(cfg.baseline) + int'($urandom_range(30, 1500));
      end else begin
        seg_target = int'(cfg.baseline) - int'($urandom_range(30, 1500));
      end
    end
    seg_left--;
    if (seg_kind == 8) begin
      s = smp_t'($urandom);
    end else if (seg_kind == 9) begin
      s = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      s = clip_smp(seg_target + int'($urandom_range(0, 40)) - 20);
    end
    sample_q.push_back(s);
  endtask

  // Idle once nothing is queued, in flight or awaited
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_q.size() != 0 || s_axis_tvalid || bend_exp_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Sample driver
  int  drv_gap = 0;
  bit  drv_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_bend(s_axis_tdata[SAMPLE_BITS-1:0]);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'(sample_q.pop_front());
          if ($urandom_range(0, 39) == 0) drv_calm = ~drv_calm;
          drv_gap = pick_gap(drv_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  int      mon_stall = 0;
  bit      mon_calm = 1'b0;
  result_t want_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (bend_exp_q.size() == 0) begin
          $display("%0t: result with none expected, tdata %h", $time, m_axis_tdata);
          err_cnt++;
        end else begin
          want_res = bend_exp_q.pop_front();
          if (m_axis_tdata[0] !== want_res.bent) begin
            $display("%0t: bent exp %0b got %0b", $time, want_res.bent, m_axis_tdata[0]);
            err_cnt++;
          end
          if (m_axis_tdata[1] !== want_res.raw_decision) begin
            $display("%0t: raw_decision exp %0b got %0b", $time,
                     want_res.raw_decision, m_axis_tdata[1]);
            err_cnt++;
          end
          if (m_axis_tdata[3:2] !== want_res.rule_used) begin
            $display("%0t: rule_used exp %0d got %0d", $time,
                     want_res.rule_used, m_axis_tdata[3:2]);
            err_cnt++;
          end
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) mon_calm = ~mon_calm;
        mon_stall = ($urandom_range(0, 2) == 0) ? pick_gap(mon_calm) : 0;
        m_axis_tready <= (mon_stall == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int ph;
    bit warm_first;

    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Auto range both ways, zero stable count, baseline written in warm-up
    cfg_write(REG_BASELINE, 32'd2000);
    cfg_write(REG_WARMUP_TICKS, 32'd2);
    cfg_write(REG_STABLE_COUNT, 32'd0);
    cfg_write(REG_RANGE_NEEDED, 32'd50);
    cfg_write(REG_FALLBACK_BAND, 32'd100);
    sample_q.push_back(12'd2000);
    sample_q.push_back(12'd1000);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'd2000);
    sample_q.push_back(12'd2101);
    wait_idle();

    // Band only, zero band, longest debounce
    cfg_write(REG_RANGE_NEEDED, 32'd4095);
    cfg_write(REG_FALLBACK_BAND, 32'd0);
    cfg_write(REG_STABLE_COUNT, 32'd15);
    sample_q.push_back(12'd2000);
    sample_q.push_back(12'd2001);
    sample_q.push_back(12'd1999);
    wait_idle();

    // Set points, falling then rising bends, around the midpoint
    cfg_write(REG_STABLE_COUNT, 32'd1);
    cfg_write(REG_USE_SET_POINTS, 32'd1);
    cfg_write(REG_SET_MIDPOINT, 32'd2048);
    cfg_write(REG_BEND_RISES, 32'd0);
    sample_q.push_back(12'd2047);
    sample_q.push_back(12'd2048);
    sample_q.push_back(12'd2049);
    wait_idle();
    cfg_write(REG_BEND_RISES, 32'd1);
    sample_q.push_back(12'd2049);
    sample_q.push_back(12'd2048);
    wait_idle();

    // Baseline written after warm-up keeps min/max
    cfg_write(REG_USE_SET_POINTS, 32'd0);
    cfg_write(REG_RANGE_NEEDED, 32'd50);
    cfg_write(REG_BASELINE, 32'd4095);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd0);
    wait_idle();

    // Zero warm-up, widest band, zero range
    cfg_write(REG_WARMUP_TICKS, 32'd0);
    cfg_write(REG_BASELINE, 32'd0);
    cfg_write(REG_FALLBACK_BAND, 32'd4095);
    cfg_write(REG_RANGE_NEEDED, 32'd0);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'd4095);
    sample_q.push_back(12'd1);
    wait_idle();

    // Random settings, realistic bend profiles
    for (ph = 0; ph < 12; ph++) begin
      warm_first = $urandom_range(0, 1);
      if (warm_first) cfg_write(REG_WARMUP_TICKS, pick_warmup());
      cfg_write(REG_BASELINE, pick12());
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_SET_MIDPOINT, PDATA_W'(
                  clip_smp(int'(cfg.baseline) + int'($urandom_range(0, 600)) - 300)));
      end else begin
        cfg_write(REG_SET_MIDPOINT, pick12());
      end
      cfg_write(REG_BEND_RISES, $urandom_range(0, 1));
      cfg_write(REG_USE_SET_POINTS, PDATA_W'($urandom_range(0, 2) == 0));
      cfg_write(REG_STABLE_COUNT, $urandom_range(0, 15));
      cfg_write(REG_RANGE_NEEDED, pick_threshold());
      cfg_write(REG_FALLBACK_BAND, pick_threshold());
      if (!warm_first) cfg_write(REG_WARMUP_TICKS, pick_warmup());

      n = $urandom_range(90, 150);
      if ($urandom_range(0, 1)) begin
        // split phase: move the baseline part-way through
        repeat (n / 2) queue_sample();
        wait_idle();
        cfg_write(REG_BASELINE, pick12());
        if ($urandom_range(0, 2) == 0) cfg_write(REG_STABLE_COUNT, $urandom_range(0, 15));
        repeat (n - n / 2) queue_sample();
      end else begin
        repeat (n) queue_sample();
      end
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (err_cnt == 0 && bend_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
